// ===== src/kscu_pkg.sv =====
// ============================================================================
// kscu_pkg: shared types and constants for colex k-subset unranking
// Field widths, the saturation value of the binomial table, the controller
// state type and the command and status groups between control and datapath.
// ============================================================================
package kscu_pkg;

    localparam int MAX_SET_DEF = 32;
    localparam int K_CAP       = 32;
    localparam int RANK_W      = 30;
    localparam int SIZE_W      = 6;
    localparam int ELEM_W      = 6;
    localparam int JW          = 6;
    localparam int VAL_W       = 31;

    // Binomials are stored saturated at 2**30, which exceeds every rank.
    localparam logic [VAL_W-1:0] SAT_VAL = 31'h4000_0000;

    typedef enum logic [2:0] {
        ST_FILL_RD,
        ST_FILL_WR,
        ST_IDLE,
        ST_ISSUE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic fill_rd;
        logic fill_wr;
        logic load;
        logic issue;
        logic walk;
    } t_cmd;

    typedef struct packed {
        logic fill_last;
        logic k_zero;
        logic gt;
        logic j_one;
    } t_sts;

endpackage

// ===== src/kscu_ram.sv =====
// ============================================================================
// kscu_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module kscu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/kscu_ctrl.sv =====
// ============================================================================
// kscu_ctrl: sequencing controller
// Builds the binomial table after reset, then takes one item at a time and
// steps the datapath through the colex walk until the last element is out.
// ============================================================================
module kscu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  kscu_pkg::t_sts i_sts,
    output kscu_pkg::t_cmd o_cmd,
    output logic           o_busy
);

    import kscu_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL_RD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL_RD: begin
                n_state = ST_FILL_WR;
            end
            ST_FILL_WR: begin
                n_state = i_sts.fill_last ? ST_IDLE : ST_FILL_RD;
            end
            ST_IDLE: begin
                if (i_start && !i_sts.k_zero) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = ST_WALK;
            end
            ST_WALK: begin
                if (!i_sts.gt && i_sts.j_one) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_FILL_RD: o_cmd.fill_rd = 1'b1;
            ST_FILL_WR: o_cmd.fill_wr = 1'b1;
            ST_IDLE:    o_cmd.load    = i_start;
            ST_ISSUE:   o_cmd.issue   = 1'b1;
            ST_WALK:    o_cmd.walk    = 1'b1;
            default:    o_cmd         = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== src/kscu_dp.sv =====
// ============================================================================
// kscu_dp: table and walk datapath
// Holds the saturated binomial table C(x, j) in RAM, the fill counters, the
// walk cursor, the remaining rank and the registered result outputs.
// ============================================================================
module kscu_dp #(
    parameter int MAX_SET = kscu_pkg::MAX_SET_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  kscu_pkg::t_cmd              i_cmd,
    output kscu_pkg::t_sts              o_sts,
    input  logic [kscu_pkg::RANK_W-1:0] i_rank,
    input  logic [kscu_pkg::SIZE_W-1:0] i_subset_size,
    input  logic [kscu_pkg::SIZE_W-1:0] i_set_size,
    output logic                        o_valid,
    output logic [kscu_pkg::ELEM_W-1:0] o_element,
    output logic                        o_last,
    output logic                        o_rank_too_large
);

    import kscu_pkg::*;

    localparam int XW    = $clog2(MAX_SET + 1);
    localparam int AW    = XW + JW;
    localparam int DEPTH = (MAX_SET + 1) * (2 ** JW);
    localparam int KMAX  = (MAX_SET < K_CAP) ? MAX_SET : K_CAP;
    localparam logic [XW-1:0] X_LAST = XW'(MAX_SET);
    localparam logic [JW-1:0] J_LAST = JW'(KMAX);

    logic [XW-1:0]     r_fx;
    logic [JW-1:0]     r_fj;
    logic [VAL_W-1:0]  r_prev;
    logic [XW-1:0]     r_x;
    logic [JW-1:0]     r_j;
    logic [RANK_W-1:0] r_rem;
    logic              r_first;
    logic              r_too;
    logic              r_valid;
    logic [ELEM_W-1:0] r_elem;
    logic              r_last;
    logic              r_too_out;

    logic [VAL_W-1:0]  rdata;
    logic [AW-1:0]     raddr;
    logic [VAL_W-1:0]  wdata;
    logic [VAL_W:0]    sum;
    logic [XW-1:0]     n_clamped;
    logic [JW-1:0]     k_clamped;
    logic              gt;
    logic              emit;

    assign n_clamped = (i_set_size > SIZE_W'(MAX_SET)) ? X_LAST : i_set_size[XW-1:0];
    assign k_clamped = (i_subset_size > SIZE_W'(KMAX)) ? J_LAST : i_subset_size[JW-1:0];

    assign gt   = rdata > {1'b0, r_rem};
    assign emit = i_cmd.walk && !gt;
    assign sum  = {1'b0, r_prev} + {1'b0, rdata};

    always_comb begin
        if (r_fx == '0) begin
            wdata = (r_fj == '0) ? VAL_W'(1) : '0;
        end else if (sum >= {1'b0, SAT_VAL}) begin
            wdata = SAT_VAL;
        end else begin
            wdata = sum[VAL_W-1:0];
        end
    end

    always_comb begin
        raddr = {r_x, r_j};
        if (i_cmd.fill_rd) begin
            raddr = {((r_fx == '0) ? XW'(0) : r_fx - XW'(1)), r_fj};
        end else if (i_cmd.walk) begin
            raddr = gt ? {r_x - XW'(1), r_j} : {r_x, r_j - JW'(1)};
        end
    end

    kscu_ram #(
        .WIDTH(VAL_W),
        .DEPTH(DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.fill_wr),
        .i_waddr ({r_fx, r_fj}),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx    <= '0;
            r_fj    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit;
            if (i_cmd.fill_wr) begin
                if (r_fj == J_LAST) begin
                    r_fj <= '0;
                    r_fx <= r_fx + XW'(1);
                end else begin
                    r_fj <= r_fj + JW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            r_prev <= (r_fj == J_LAST) ? '0 : rdata;
        end
        if (i_cmd.load) begin
            r_x     <= n_clamped;
            r_j     <= k_clamped;
            r_rem   <= i_rank;
        end
        if (i_cmd.issue) begin
            r_first <= 1'b1;
        end
        if (i_cmd.walk) begin
            r_first <= 1'b0;
            if (r_first) begin
                r_too <= !gt;
            end
            if (gt) begin
                r_x <= r_x - XW'(1);
            end else begin
                r_j   <= r_j - JW'(1);
                r_rem <= r_rem - rdata[RANK_W-1:0];
            end
        end
        if (emit) begin
            r_elem    <= ELEM_W'(r_x) + ELEM_W'(1);
            r_last    <= (r_j == JW'(1));
            r_too_out <= r_first ? 1'b1 : r_too;
        end
    end

    assign o_sts.fill_last = (r_fx == X_LAST) && (r_fj == J_LAST);
    assign o_sts.k_zero    = (i_subset_size == '0);
    assign o_sts.gt        = gt;
    assign o_sts.j_one     = (r_j == JW'(1));

    assign o_valid          = r_valid;
    assign o_element        = r_elem;
    assign o_last           = r_last;
    assign o_rank_too_large = r_too_out;

    a_valid_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(i_cmd.walk))
        else $error("Result strobe without a walk step.");

    a_walk_j_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.walk |-> (r_j != '0))
        else $error("Walk step with no element left to emit.");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |=> !r_valid)
        else $error("Result follows the last element of an item directly.");

endmodule

// ===== src/ksubset_colex_unrank.sv =====
// ============================================================================
// ksubset_colex_unrank: colex unranking of k-subsets
// Returns the k-subset of {1..n} with a given colex rank, largest first.
// ============================================================================
// After reset the block builds its binomial table in RAM, each entry through a
// read state and a write state, and holds busy high until the table is complete.
// An item is accepted when start is high and busy is low. With a subset size
// of zero the item produces no results and busy stays low. Otherwise busy is
// high through an issue state and the walk steps: one step per element plus
// one per decrement of the cursor, at most n + k steps, each step being one
// table read and one compare.
// Elements appear on o_element one per strobe, largest first, o_last marks the
// final one and o_rank_too_large is repeated on every element of the item.
// The receiver cannot stall: each result is present for exactly one cycle.
// ============================================================================
module ksubset_colex_unrank #(
    parameter int MAX_SET = kscu_pkg::MAX_SET_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [kscu_pkg::RANK_W-1:0] i_rank,
    input  logic [kscu_pkg::SIZE_W-1:0] i_subset_size,
    input  logic [kscu_pkg::SIZE_W-1:0] i_set_size,
    output logic                        o_valid,
    output logic [kscu_pkg::ELEM_W-1:0] o_element,
    output logic                        o_last,
    output logic                        o_rank_too_large
);

    import kscu_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kscu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    kscu_dp #(
        .MAX_SET(MAX_SET)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_rank           (i_rank),
        .i_subset_size    (i_subset_size),
        .i_set_size       (i_set_size),
        .o_valid          (o_valid),
        .o_element        (o_element),
        .o_last           (o_last),
        .o_rank_too_large (o_rank_too_large)
    );

endmodule
